// ----- hw/rtl/sit_pkg.sv -----
// Shared types and constants for the sorted insert table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sit_pkg;

  localparam int unsigned DEPTH_DEF       = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned CAP_W   = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INS_START,
    OP_INS_SHIFT,
    OP_INS_PUT,
    OP_FULL,
    OP_RANGE,
    OP_NULL,
    OP_RD_START,
    OP_CAPTURE,
    OP_REM_FIRST,
    OP_REM_SHIFT
  } sit_op_e;

  typedef struct packed {
    sit_op_e op;
    logic    out_load;
  } sit_cmd_t;

  typedef struct packed {
    logic full;
    logic idx_ok;
    logic cnt_zero;
    logic ge;
    logic ptr_one;
    logic rem_more;
  } sit_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_insert_table_core.sv -----
// Top level of the sorted insert table: joins the controller and the datapath.
// Depends on sit_pkg, sit_ctrl and sit_dp.
//
// The table holds up to DEPTH unsigned values in ascending order in a single-port-write,
// registered-read memory, and one transaction runs at a time. The memory moves one entry per
// cycle, so an insert takes longer the more entries lie above its landing position, and a
// remove the more entries lie above its index; lookups, rejected and unused commands move none.
// A finished result sits in an output register, so the next transaction is accepted while
// that result waits to be taken. The limit register is written through cfg_we_i and
// cfg_wdata_i; the user must write it only while the block is idle, which the block itself
// does not enforce. The entries need no clearing after reset.
`default_nettype none

module sorted_insert_table_core
  import sit_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CMD_W-1:0]   cmd_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic [INDEX_W-1:0] index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [VALUE_W-1:0]      read_value_o,
  output logic [POS_W-1:0]        position_o,
  output logic [STAT_W-1:0]       status_o,
  output logic [CNT_W-1:0]        entry_count_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CAP_W-1:0]   cfg_wdata_i
);

  sit_cmd_t  dp_cmd;
  sit_stat_t dp_stat;

  sit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  sit_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .index_i       (index_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .read_value_o  (read_value_o),
    .position_o    (position_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/sit_ctrl.sv -----
// Controller state machine of the sorted insert table.
// Depends on sit_pkg; drives the datapath through sit_cmd_t and reads sit_stat_t.
`default_nettype none

module sit_ctrl
  import sit_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [CMD_W-1:0] cmd_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire sit_stat_t        stat_i,
  output sit_cmd_t              cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS     = 3'd1;
  localparam logic [2:0] S_INS_PUT = 3'd2;
  localparam logic [2:0] S_LK      = 3'd3;
  localparam logic [2:0] S_REM_RD  = 3'd4;
  localparam logic [2:0] S_REM_SH  = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '{op: OP_NONE, out_load: 1'b0};
    in_ready_o  = (state_q == S_IDLE);
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_INSERT: begin
              if (stat_i.full) begin
                cmd_o.op = OP_FULL;
                state_d  = S_FIN;
              end else begin
                cmd_o.op = OP_INS_START;
                state_d  = stat_i.cnt_zero ? S_INS_PUT : S_INS;
              end
            end
            CMD_LOOKUP: begin
              if (stat_i.idx_ok) begin
                cmd_o.op = OP_RD_START;
                state_d  = S_LK;
              end else begin
                cmd_o.op = OP_RANGE;
                state_d  = S_FIN;
              end
            end
            CMD_REMOVE: begin
              if (stat_i.idx_ok) begin
                cmd_o.op = OP_RD_START;
                state_d  = S_REM_RD;
              end else begin
                cmd_o.op = OP_RANGE;
                state_d  = S_FIN;
              end
            end
            default: begin
              cmd_o.op = OP_NULL;
              state_d  = S_FIN;
            end
          endcase
        end
      end
      S_INS: begin
        if (stat_i.ge) begin
          cmd_o.op = OP_INS_SHIFT;
          state_d  = stat_i.ptr_one ? S_INS_PUT : S_INS;
        end else begin
          cmd_o.op = OP_INS_PUT;
          state_d  = S_FIN;
        end
      end
      S_INS_PUT: begin
        cmd_o.op = OP_INS_PUT;
        state_d  = S_FIN;
      end
      S_LK: begin
        cmd_o.op = OP_CAPTURE;
        state_d  = S_FIN;
      end
      S_REM_RD: begin
        cmd_o.op = OP_REM_FIRST;
        state_d  = stat_i.rem_more ? S_REM_SH : S_FIN;
      end
      S_REM_SH: begin
        cmd_o.op = OP_REM_SHIFT;
        state_d  = stat_i.rem_more ? S_REM_SH : S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sit_dp.sv -----
// Datapath of the sorted insert table: entry memory, count, limit register and result registers.
// Depends on sit_pkg; steered by sit_ctrl through sit_cmd_t.
`default_nettype none

module sit_dp
  import sit_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic [INDEX_W-1:0] index_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CAP_W-1:0]   cfg_wdata_i,
  input  wire sit_cmd_t           cmd_i,
  output sit_stat_t               stat_o,
  output logic [VALUE_W-1:0]      read_value_o,
  output logic [POS_W-1:0]        position_o,
  output logic [STAT_W-1:0]       status_o,
  output logic [CNT_W-1:0]        entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned IW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [LW-1:0] DepthL = LW'(DEPTH);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata;

  logic [CW-1:0]          count_q, count_d;
  logic [CAP_W-1:0]       cap_q;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [VALUE_WIDTH-1:0] rd_q, rd_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [STAT_W-1:0]      st_q, st_d;

  logic [VALUE_WIDTH-1:0] rv_out_q;
  logic [POS_W-1:0]       pos_out_q;
  logic [STAT_W-1:0]      st_out_q;
  logic [CNT_W-1:0]       cnt_out_q;

  logic [LW-1:0]          cap_ext, limit, count_ext;
  logic [IW-1:0]          idx_ext;
  logic [AW-1:0]          idx_addr, ptr_inc, ptr_dec;
  logic [VALUE_WIDTH-1:0] val_in;

  assign val_in    = VALUE_WIDTH'(value_i);
  assign cap_ext   = LW'(cap_q);
  assign limit     = (cap_ext < DepthL) ? cap_ext : DepthL;
  assign count_ext = LW'(count_q);
  assign idx_ext   = IW'(index_i);
  assign idx_addr  = AW'(idx_ext);
  assign ptr_inc   = ptr_q + 1'b1;
  assign ptr_dec   = ptr_q - 1'b1;

  assign stat_o.full     = (count_ext >= limit);
  assign stat_o.idx_ok   = (idx_ext < IW'(count_q));
  assign stat_o.cnt_zero = (count_q == '0);
  assign stat_o.ge       = (rdata_q >= val_q);
  assign stat_o.ptr_one  = (ptr_q == AW'(1));
  assign stat_o.rem_more = ((CW+1)'(ptr_q) + (CW+1)'(1)) < (CW+1)'(count_q);

  always_comb begin
    we      = 1'b0;
    re      = 1'b0;
    waddr   = ptr_q;
    wdata   = rdata_q;
    raddr   = '0;
    count_d = count_q;
    ptr_d   = ptr_q;
    val_d   = val_q;
    rd_d    = rd_q;
    pos_d   = pos_q;
    st_d    = st_q;
    case (cmd_i.op)
      OP_INS_START: begin
        val_d = val_in;
        ptr_d = AW'(count_q);
        rd_d  = '0;
        st_d  = ST_OK;
        re    = (count_q != '0);
        raddr = AW'(count_q - 1'b1);
      end
      OP_INS_SHIFT: begin
        we    = 1'b1;
        ptr_d = ptr_dec;
        re    = (ptr_q > AW'(1));
        raddr = ptr_dec - 1'b1;
      end
      OP_INS_PUT: begin
        we      = 1'b1;
        wdata   = val_q;
        pos_d   = POS_W'(ptr_q);
        count_d = count_q + 1'b1;
      end
      OP_FULL: begin
        rd_d  = '0;
        pos_d = '0;
        st_d  = ST_FULL;
      end
      OP_RANGE: begin
        rd_d  = '0;
        pos_d = index_i;
        st_d  = ST_RANGE;
      end
      OP_NULL: begin
        rd_d  = '0;
        pos_d = '0;
        st_d  = ST_OK;
      end
      OP_RD_START: begin
        re    = 1'b1;
        raddr = idx_addr;
        ptr_d = idx_addr;
        rd_d  = '0;
        pos_d = index_i;
        st_d  = ST_OK;
      end
      OP_CAPTURE: begin
        rd_d = rdata_q;
      end
      OP_REM_FIRST: begin
        rd_d    = rdata_q;
        count_d = count_q - 1'b1;
        re      = stat_o.rem_more;
        raddr   = ptr_inc;
      end
      OP_REM_SHIFT: begin
        we    = 1'b1;
        ptr_d = ptr_inc;
        re    = stat_o.rem_more;
        raddr = ptr_inc + 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    val_q <= val_d;
    rd_q  <= rd_d;
    pos_q <= pos_d;
    st_q  <= st_d;
    if (cmd_i.out_load) begin
      rv_out_q  <= rd_q;
      pos_out_q <= pos_q;
      st_out_q  <= st_q;
      cnt_out_q <= CNT_W'(count_q);
    end
  end

  assign read_value_o  = VALUE_W'(rv_out_q);
  assign position_o    = pos_out_q;
  assign status_o      = st_out_q;
  assign entry_count_o = cnt_out_q;

endmodule

`default_nettype wire
